@@ hw/rtl/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared word types and widths for the window peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package wpf_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned COL_W  = 13;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned OCOL_W = 11;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;
  localparam logic [1:0] CFG_HALF_BOX     = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]  window_value;
    logic [OCOL_W-1:0] window_col;
    logic [ROW_W-1:0]  window_row;
    logic              run_last;
  } out_word_t;

  // Position tag of a pixel travelling down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

endpackage

`default_nettype wire

@@ hw/rtl/wpf_line_store.sv @@
// ----------------------------------------------------------------------------
// wpf_line_store
// Banked line memories, one bank per image row held, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wpf_line_store import wpf_pkg::*; #(
  parameter int unsigned NLINES = 5,
  parameter int unsigned DEPTH  = 2048
) (
  input  wire logic                      clk_i,
  input  wire logic                      acc_i,
  input  wire logic [$clog2(NLINES)-1:0] wbank_i,
  input  wire logic [$clog2(DEPTH)-1:0]  addr_i,
  input  wire logic [PIX_W-1:0]          wdata_i,
  output logic [PIX_W-1:0]               rd_o [NLINES]
);

  for (genvar i = 0; i < NLINES; i++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];
    always_ff @(posedge clk_i) begin
      if (acc_i && (wbank_i == ($clog2(NLINES))'(i))) begin
        mem[addr_i] <= wdata_i;
      end
      if (acc_i) begin
        rd_o[i] <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpf_window.sv @@
// ----------------------------------------------------------------------------
// wpf_window
// Column assembly, window shift registers and the peak decision.
// ----------------------------------------------------------------------------
`default_nettype none

module wpf_window import wpf_pkg::*; #(
  parameter int unsigned MAX_HALF_BOX = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire pos_t                  s1_i,
  input  wire logic [$clog2(2*MAX_HALF_BOX+1)-1:0] rmod_i,
  input  wire logic [PIX_W-1:0]      pix_i,
  input  wire logic [PIX_W-1:0]      rd_i [2*MAX_HALF_BOX+1],
  input  wire logic [PIX_W-1:0]      thr_i,
  input  wire logic [1:0]            box_i,
  output pos_t                       s2_o,
  output logic                       peak_o,
  output logic [PIX_W-1:0]           load_o [(2*MAX_HALF_BOX+1)*(2*MAX_HALF_BOX+1)]
);

  localparam int unsigned SIDE = 2 * MAX_HALF_BOX + 1;
  localparam int unsigned LW   = $clog2(SIDE);
  localparam int unsigned NE   = SIDE * SIDE;

  logic [PIX_W-1:0] col_vec [SIDE];
  logic [PIX_W-1:0] win_q [SIDE][SIDE];
  pos_t             s2_q;

  // Element d of the column is the row d lines above the newest one.
  always_comb begin
    col_vec[0] = pix_i;
    for (int d = 1; d < SIDE; d++) begin
      if (rmod_i >= LW'(d)) begin
        col_vec[d] = rd_i[rmod_i - LW'(d)];
      end else begin
        col_vec[d] = rd_i[rmod_i + LW'(SIDE - d)];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_i.valid) begin
      win_q[0] <= col_vec;
      for (int j = 1; j < SIDE; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en_i) begin
      s2_q <= s1_i;
    end
  end

  logic [PIX_W-1:0] centre;
  logic             greater;
  logic [COL_W-1:0] twob;

  always_comb begin
    centre  = win_q[LW'(box_i)][LW'(box_i)];
    greater = 1'b0;
    for (int a = 0; a < SIDE; a++) begin
      for (int d = 0; d < SIDE; d++) begin
        if ((a <= 2 * int'(box_i)) && (d <= 2 * int'(box_i)) && (win_q[a][d] > centre)) begin
          greater = 1'b1;
        end
      end
    end
  end

  assign twob   = {{(COL_W-3){1'b0}}, box_i, 1'b0};
  assign peak_o = s2_q.valid && (s2_q.col >= twob) && ({1'b0, s2_q.row} >= twob)
                  && (centre >= thr_i) && !greater;
  assign s2_o   = s2_q;

  // Raster-order window for each legal box size; age indexes run backwards.
  logic [PIX_W-1:0] cand [MAX_HALF_BOX][NE];
  for (genvar bb = 1; bb <= MAX_HALF_BOX; bb++) begin : g_box
    localparam int unsigned BS = 2 * bb + 1;
    for (genvar idx = 0; idx < NE; idx++) begin : g_el
      if (idx < BS * BS) begin : g_in
        assign cand[bb-1][idx] = win_q[2*bb - idx % BS][2*bb - idx / BS];
      end else begin : g_out
        assign cand[bb-1][idx] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      load_o[i] = cand[0][i];
      for (int bb = 2; bb <= MAX_HALF_BOX; bb++) begin
        if (box_i == 2'(bb)) begin
          load_o[i] = cand[bb-1][i];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wpf_run_out.sv @@
// ----------------------------------------------------------------------------
// wpf_run_out
// Holds one peak's window and sends it out element by element.
// ----------------------------------------------------------------------------
`default_nettype none

module wpf_run_out import wpf_pkg::*; #(
  parameter int unsigned MAX_HALF_BOX = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [PIX_W-1:0]  load_vec_i [(2*MAX_HALF_BOX+1)*(2*MAX_HALF_BOX+1)],
  input  wire logic [1:0]        box_i,
  input  wire logic [COL_W-1:0]  c0_i,
  input  wire logic [ROW_W-1:0]  r0_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o
);

  localparam int unsigned SIDE = 2 * MAX_HALF_BOX + 1;
  localparam int unsigned NE   = SIDE * SIDE;
  localparam int unsigned KW   = $clog2(SIDE);
  localparam int unsigned RW   = $clog2(NE + 1);

  logic [PIX_W-1:0] snap_q [NE];
  logic             busy_q;
  logic [RW-1:0]    rem_q;
  logic [KW-1:0]    k_q, side_m1_q;
  logic [COL_W-1:0] c0_q, col_q;
  logic [ROW_W-1:0] row_q;
  logic             pop, last;
  logic [KW-1:0]    side_m1;

  assign pop     = busy_q && !out_stall_i;
  assign last    = (rem_q == RW'(1));
  assign free_o  = !busy_q || (pop && last);
  assign side_m1 = {{(KW-2){1'b0}}, box_i} << 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load_i) begin
      busy_q <= 1'b1;
    end else if (pop && last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q    <= load_vec_i;
      rem_q     <= RW'((side_m1 + 1'b1) * (side_m1 + 1'b1));
      k_q       <= '0;
      side_m1_q <= side_m1;
      c0_q      <= c0_i;
      col_q     <= c0_i;
      row_q     <= r0_i;
    end else if (pop) begin
      for (int i = 0; i < NE - 1; i++) begin
        snap_q[i] <= snap_q[i+1];
      end
      rem_q <= rem_q - 1'b1;
      if (k_q == side_m1_q) begin
        k_q   <= '0;
        col_q <= c0_q;
        row_q <= row_q + 1'b1;
      end else begin
        k_q   <= k_q + 1'b1;
        col_q <= col_q + 1'b1;
      end
    end
  end

  assign out_valid_o             = busy_q;
  assign out_word_o.window_value = snap_q[0];
  assign out_word_o.window_col   = col_q[OCOL_W-1:0];
  assign out_word_o.window_row   = row_q;
  assign out_word_o.run_last     = last;

endmodule

`default_nettype wire

@@ hw/rtl/window_peak_finder.sv @@
// ----------------------------------------------------------------------------
// window_peak_finder
// Sliding-window local maximum detector over a raster pixel stream.
// ----------------------------------------------------------------------------
// The pixel completing a peak's window passes stage one and stage two
// before its run is loaded; a run then sends side*side words (9 or 25).
// Throughput: one pixel per cycle; the input stalls only while a run is
// still being sent and the next window is also a peak (serialiser bound).
// Reset clears the position counters, the pipeline valid flags and the
// registers to their documented values; line memories are not cleared.
`default_nettype none

module window_peak_finder import wpf_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_HALF_BOX = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_word_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned NLINES = 2 * MAX_HALF_BOX + 1;
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned LW     = $clog2(NLINES);

  // Configuration registers.
  logic [11:0] fw_q;
  logic [12:0] fh_q;
  logic [15:0] thr_q;
  logic [1:0]  hb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 12'd2048;
      fh_q  <= 13'd2048;
      thr_q <= 16'd100;
      hb_q  <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q  <= cfg_data_i[11:0];
        CFG_FRAME_HEIGHT: fh_q  <= cfg_data_i[12:0];
        CFG_THRESHOLD:    thr_q <= cfg_data_i;
        CFG_HALF_BOX:     hb_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into their legal ranges.
  logic [13:0] w_eff;
  logic [12:0] h_eff;
  logic [1:0]  b_eff;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = 14'd1;
    end else if ({2'b0, fw_q} > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = {2'b0, fw_q};
    end
    if (fh_q == '0) begin
      h_eff = 13'd1;
    end else if (fh_q > 13'd4096) begin
      h_eff = 13'd4096;
    end else begin
      h_eff = fh_q;
    end
    if (hb_q == '0) begin
      b_eff = 2'd1;
    end else if (hb_q > 2'(MAX_HALF_BOX)) begin
      b_eff = 2'(MAX_HALF_BOX);
    end else begin
      b_eff = hb_q;
    end
  end

  logic hold, en, in_acc;
  assign in_acc     = in_valid_i && !hold;
  assign en         = !hold;
  assign in_stall_o = hold;

  // Position tracking. The counters hold the position of the next pixel,
  // which may be out of range when the frame size has just been reduced.
  logic [CW-1:0] col_q;
  logic [11:0]   row_q;
  logic [LW-1:0] rmod_q;
  logic [13:0]   c_a, c_n;
  logic [12:0]   r_a, r_n;
  logic [LW-1:0] m_a, m_n;

  always_comb begin
    c_a = in_word_i.frame_start ? '0 : {{(14-CW){1'b0}}, col_q};
    r_a = in_word_i.frame_start ? '0 : {1'b0, row_q};
    m_a = in_word_i.frame_start ? '0 : rmod_q;
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = r_a + 1'b1;
      m_a = (m_a == LW'(NLINES - 1)) ? '0 : m_a + 1'b1;
    end
    if (r_a >= h_eff) begin
      r_a = '0;
      m_a = '0;
    end
    c_n = c_a + 1'b1;
    r_n = r_a;
    m_n = m_a;
    if (c_n >= w_eff) begin
      c_n = '0;
      r_n = r_a + 1'b1;
      m_n = (m_a == LW'(NLINES - 1)) ? '0 : m_a + 1'b1;
      if (r_n >= h_eff) begin
        r_n = '0;
        m_n = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rmod_q <= '0;
    end else if (in_acc) begin
      col_q  <= c_n[CW-1:0];
      row_q  <= r_n[11:0];
      rmod_q <= m_n;
    end
  end

  // Each pixel is written to the bank of its own row and the same column
  // is read from every bank, giving the column above it in the cycle after.
  logic [PIX_W-1:0] rd [NLINES];

  wpf_line_store #(
    .NLINES (NLINES),
    .DEPTH  (MAX_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .acc_i   (in_acc),
    .wbank_i (m_a),
    .addr_i  (c_a[CW-1:0]),
    .wdata_i (in_word_i.pixel_value),
    .rd_o    (rd)
  );

  // Stage one carries the pixel alongside the memory read.
  pos_t             s1_q;
  logic [LW-1:0]    s1_rmod_q;
  logic [PIX_W-1:0] s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
    end else begin
      if (en) begin
        s1_q.valid <= in_acc;
      end
      if (in_acc) begin
        s1_q.col  <= c_a[COL_W-1:0];
        s1_q.row  <= r_a[ROW_W-1:0];
        s1_rmod_q <= m_a;
        s1_pix_q  <= in_word_i.pixel_value;
      end
    end
  end

  pos_t             s2;
  logic             peak;
  logic [PIX_W-1:0] load_vec [NLINES*NLINES];
  logic             free;

  wpf_window #(
    .MAX_HALF_BOX (MAX_HALF_BOX)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .s1_i   (s1_q),
    .rmod_i (s1_rmod_q),
    .pix_i  (s1_pix_q),
    .rd_i   (rd),
    .thr_i  (thr_q),
    .box_i  (b_eff),
    .s2_o   (s2),
    .peak_o (peak),
    .load_o (load_vec)
  );

  // A peak waits in stage two while the previous run is still going out.
  assign hold = peak && !free;

  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] r0;
  assign c0 = s2.col - {{(COL_W-3){1'b0}}, b_eff, 1'b0};
  assign r0 = s2.row - {{(ROW_W-3){1'b0}}, b_eff, 1'b0};

  wpf_run_out #(
    .MAX_HALF_BOX (MAX_HALF_BOX)
  ) u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (peak && free),
    .load_vec_i  (load_vec),
    .box_i       (b_eff),
    .c0_i        (c0),
    .r0_i        (r0),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_hold_keeps_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> s2.valid)
    else $error("held peak lost from stage two");

  a_rmod_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmod_q <= LW'(NLINES - 1))
    else $error("line bank index out of range");

  a_hold_no_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold && out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("run dropped while a peak waits");

endmodule

`default_nettype wire

@@ dv/tb_window_peak_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_peak_finder
// Self-checking bench for the sliding-window peak finder. Pixel words are
// pushed through a queue-fed driver. Every accepted pixel is run through a
// local model of the line stores and the window. The expected window runs
// are checked word by word against what the monitor sees. Several register
// settings and idling patterns are covered in turn.
// ----------------------------------------------------------------------------
module tb_window_peak_finder;
  import wpf_pkg::*;

  localparam int unsigned MODEL_WIDTH = 2048;
  localparam int unsigned MODEL_LINES = 5;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_FRAME_WIDTH;
  logic [15:0] cfg_data_i = '0;

  window_peak_finder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the register file, as the block should hold it.
  logic [11:0] frame_width_q = 12'd2048;
  logic [12:0] frame_height_q = 13'd2048;
  logic [15:0] threshold_q = 16'd100;
  logic [1:0]  half_box_q = 2'd2;

  // Local copy of the line stores and the raster position.
  logic [15:0] line_mem [MODEL_LINES*MODEL_WIDTH];
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;

  in_word_t  pixel_q [$];
  out_word_t window_run_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Advances the raster position for one pixel, stores it, and queues the
  // whole window whenever its centre turns out to be a peak.
  function automatic void predict_pixel(in_word_t px);
    int unsigned w, h, b, side, c, r, c0, r0, l, k;
    logic [15:0] win [25];
    logic [15:0] centre;
    bit is_peak;
    out_word_t ow;
    w = (frame_width_q == 0) ? 1 : (frame_width_q > MODEL_WIDTH) ? MODEL_WIDTH : frame_width_q;
    h = (frame_height_q == 0) ? 1 : (frame_height_q > 4096) ? 4096 : frame_height_q;
    b = (half_box_q == 0) ? 1 : (half_box_q > 2) ? 2 : half_box_q;
    side = 2 * b + 1;
    if (px.frame_start) begin
      cur_col = 0;
      cur_row = 0;
    end
    // A size shrunk under the held position pushes the pixel on.
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    c = cur_col;
    r = cur_row;
    line_mem[(r % MODEL_LINES) * MODEL_WIDTH + c] = px.pixel_value;
    if (c >= 2 * b && r >= 2 * b) begin
      c0 = c - 2 * b;
      r0 = r - 2 * b;
      for (l = 0; l < side; l++)
        for (k = 0; k < side; k++)
          win[l*side+k] = line_mem[((r0 + l) % MODEL_LINES) * MODEL_WIDTH + c0 + k];
      centre = win[b*side+b];
      // Ties with the centre do not spoil a peak; only a strictly larger one does.
      is_peak = (centre >= threshold_q);
      for (l = 0; l < side * side; l++)
        if (win[l] > centre) is_peak = 0;
      if (is_peak) begin
        for (l = 0; l < side; l++)
          for (k = 0; k < side; k++) begin
            ow.window_value = win[l*side+k];
            ow.window_col = OCOL_W'(c0 + k);
            ow.window_row = ROW_W'(r0 + l);
            ow.run_last = (l == side - 1 && k == side - 1);
            window_run_q.insert(window_run_q.size(), ow);
          end
      end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  // Driver: a word is predicted as it is accepted, and a new one is offered
  // only when the line is free, so a stalled word is held unchanged.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_pixel(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: every accepted output word must match the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_run_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word %p", out_word_o);
      end else begin
        if (out_word_o !== window_run_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected %p, got %p", window_run_q[0], out_word_o);
        end
        void'(window_run_q.pop_front());
      end
    end
  end

  // Watchdog: a long spell with no word moving either way means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_window_peak_finder failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_FRAME_WIDTH:  frame_width_q = val[11:0];
      CFG_FRAME_HEIGHT: frame_height_q = val[12:0];
      CFG_THRESHOLD:    threshold_q = val;
      default:          half_box_q = val[1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every pixel is in and every window word is out, then lets
  // the pipeline settle so that no pixel is still in flight.
  task automatic drain_block();
    while (pixel_q.size() > 0 || in_valid_i || window_run_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One setting: registers, idling pattern and a stretch of pixels. Each
  // stretch opens a new frame, so no window ever reaches a stale store.
  task automatic run_setting(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] thr, input logic [15:0] box,
                             input int unsigned send_pct, input int unsigned hold_pct,
                             input int unsigned count);
    in_word_t px;
    drain_block();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_HALF_BOX, box);
    send_idle_pct = send_pct;
    stall_pct = hold_pct;
    for (int unsigned i = 0; i < count; i++) begin
      // Mostly a low background with rare bright spikes, so peaks turn up.
      if ($urandom_range(99) < 6) px.pixel_value = 16'($urandom());
      else px.pixel_value = 16'($urandom_range(200));
      px.frame_start = (i == 0) || ($urandom_range(199) == 0);
      pixel_q.insert(pixel_q.size(), px);
    end
  endtask

  initial begin
    in_word_t px;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A 5x5 frame with threshold zero: flat zeros tie everywhere, so
    // every window is a peak, until one full-scale pixel takes over.
    write_reg(CFG_FRAME_WIDTH, 16'd5);
    write_reg(CFG_FRAME_HEIGHT, 16'd5);
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_HALF_BOX, 16'd1);
    for (int unsigned i = 0; i < 25; i++) begin
      px.pixel_value = (i == 18) ? 16'hFFFF : 16'h0000;
      px.frame_start = (i == 0);
      pixel_q.insert(pixel_q.size(), px);
    end

    // Zero sizes and zero box act as one; the top threshold blocks peaks.
    run_setting(16'd0, 16'd0, 16'hFFFF, 16'd0, 87, 0, 20);
    run_setting(16'd12, 16'd7, 16'd150, 16'd2, 0, 87, 100);
    run_setting(16'd9, 16'h1FFF, 16'd100, 16'd3, 19, 19, 100);
    // Oversized width saturates to the full line, so the row never wraps here.
    run_setting(16'hFFF, 16'd6, 16'd60000, 16'd1, 0, 0, 30);
    run_setting(16'd7, 16'd4096, 16'd120, 16'd2, 87, 87, 100);
    run_setting(16'd5, 16'd5, 16'd0, 16'd2, 0, 0, 90);

    drain_block();
    if (mismatches == 0 && window_run_q.size() == 0) begin
      $display("tb_window_peak_finder passed");
    end else begin
      $display("tb_window_peak_finder failed");
    end
    $finish;
  end

endmodule
